### hdl/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg: shared types and constants
// Register map, configuration bundle and fixed constants of the regulator.
// ----------------------------------------------------------------------------
package srt_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int CODE_W     = 8;
	localparam int TIMER_W    = 16;
	localparam int MARGIN_W   = 16;

	// one degree in Q8.8
	localparam int FRAC_ONE = 256;

	localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

	localparam logic [2:0] STEP_BIG   = 3'd5;
	localparam logic [2:0] STEP_MID   = 3'd2;
	localparam logic [2:0] STEP_SMALL = 3'd1;

	localparam logic [MARGIN_W-1:0] MARGIN_LOW_RST    = 16'd6144;
	localparam logic [MARGIN_W-1:0] MARGIN_CENTER_RST = 16'd6400;
	localparam logic [MARGIN_W-1:0] MARGIN_HIGH_RST   = 16'd6656;
	localparam logic [CODE_W-1:0]   CODE_MIN_RST      = 8'd0;
	localparam logic [CODE_W-1:0]   CODE_START_RST    = 8'd128;
	localparam logic [CODE_W-1:0]   CODE_MAX_RST      = 8'd255;
	localparam logic [TIMER_W-1:0]  HOLDOFF_RST       = 16'd15;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MARGIN_LOW    = 3'd0,
		REG_MARGIN_CENTER = 3'd1,
		REG_MARGIN_HIGH   = 3'd2,
		REG_CODE_MIN      = 3'd3,
		REG_CODE_START    = 3'd4,
		REG_CODE_MAX      = 3'd5,
		REG_HOLDOFF       = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [MARGIN_W-1:0] margin_low;
		logic [MARGIN_W-1:0] margin_center;
		logic [MARGIN_W-1:0] margin_high;
		logic [CODE_W-1:0]   code_min;
		logic [CODE_W-1:0]   code_start;
		logic [CODE_W-1:0]   code_max;
		logic [TIMER_W-1:0]  holdoff_ticks;
	} cfg_t;

endpackage

### hdl/stepwise_temperature_regulator.sv
// Pipeline: an input beat is registered in the input register, then decided;
// its result beat is held in the result register until it is taken.
// Throughput: one item per cycle; a sample stalls only while the result
// register holds an untaken beat, and ticks produce no result beat.
// Reset: arst_n clears pipeline valids and regulator state asynchronously and
// loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
// stepwise_temperature_regulator: top level
// Input register, decision core and result register with stream handshakes.
// ----------------------------------------------------------------------------
module stepwise_temperature_regulator
	import srt_pkg::*;
#(
	parameter int TEMP_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [CFG_IDX_W-1:0]                cfg_index,
	input  logic [CFG_DATA_W-1:0]               cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((TEMP_WIDTH + 7) / 8) * 8-1:0] s_tdata,  // sample_temp
	input  logic                                s_tuser,  // op
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [CODE_W-1:0]                   m_tdata,  // drive_out
	output logic                                m_tuser   // code_changed
);

	cfg_t                  cfg;
	logic                  valid_s1;
	logic                  op_s1;
	logic [TEMP_WIDTH-1:0] temp_s1;
	logic                  out_valid_q;
	logic [CODE_W-1:0]     out_drive_q;
	logic                  out_chg_q;
	logic                  out_free, go;
	logic [CODE_W-1:0]     res_drive;
	logic                  res_changed;

	srt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// ticks never need the result register
	assign out_free = !out_valid_q || m_tready;
	assign go       = valid_s1 && (!op_s1 || out_free);
	assign s_tready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser;
			temp_s1 <= s_tdata[TEMP_WIDTH-1:0];
		end
	end

	srt_core #(
		.TEMP_WIDTH (TEMP_WIDTH)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.go          (go),
		.op          (op_s1),
		.temp        (temp_s1),
		.res_drive   (res_drive),
		.res_changed (res_changed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && op_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && op_s1) begin
			out_drive_q <= res_drive;
			out_chg_q   <= res_changed;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_drive_q;
	assign m_tuser  = out_chg_q;

endmodule

### hdl/srt_cfg.sv
// ----------------------------------------------------------------------------
// srt_cfg: configuration register file
// Write-only register bank; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module srt_cfg
	import srt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.margin_low    <= MARGIN_LOW_RST;
			cfg_q.margin_center <= MARGIN_CENTER_RST;
			cfg_q.margin_high   <= MARGIN_HIGH_RST;
			cfg_q.code_min      <= CODE_MIN_RST;
			cfg_q.code_start    <= CODE_START_RST;
			cfg_q.code_max      <= CODE_MAX_RST;
			cfg_q.holdoff_ticks <= HOLDOFF_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MARGIN_LOW:    cfg_q.margin_low    <= cfg_data[MARGIN_W-1:0];
				REG_MARGIN_CENTER: cfg_q.margin_center <= cfg_data[MARGIN_W-1:0];
				REG_MARGIN_HIGH:   cfg_q.margin_high   <= cfg_data[MARGIN_W-1:0];
				REG_CODE_MIN:      cfg_q.code_min      <= cfg_data[CODE_W-1:0];
				REG_CODE_START:    cfg_q.code_start    <= cfg_data[CODE_W-1:0];
				REG_CODE_MAX:      cfg_q.code_max      <= cfg_data[CODE_W-1:0];
				REG_HOLDOFF:       cfg_q.holdoff_ticks <= cfg_data[TIMER_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hdl/srt_core.sv
// ----------------------------------------------------------------------------
// srt_core: regulator state and decision logic
// Holds trend, timer and drive code; decides at most one code move per sample.
// ----------------------------------------------------------------------------
module srt_core
	import srt_pkg::*;
#(
	parameter int TEMP_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  go,
	input  logic                  op,
	input  logic [TEMP_WIDTH-1:0] temp,
	output logic [CODE_W-1:0]     res_drive,
	output logic                  res_changed
);

	// wide enough for the distance and for the two-degree threshold
	localparam int DW = (TEMP_WIDTH + 1 > 11) ? TEMP_WIDTH + 1 : 11;

	logic [TEMP_WIDTH-1:0] prev_q;
	logic                  have_q;
	logic [CODE_W-1:0]     drive_q;
	logic [TIMER_W-1:0]    timer_q;

	logic signed [TEMP_WIDTH-1:0] t, pv, lo, ce, hi;
	logic signed [DW-1:0]         delta;
	logic [DW-1:0]                adist;
	logic [2:0]                   step;
	logic [CODE_W:0]              up_sum, dn_floor;
	logic [CODE_W-1:0]            up_val, dn_val;
	logic                         passed, below, above, move_up, move_dn;

	// margins are 16-bit registers read at the sample width
	assign t  = $signed(temp);
	assign pv = $signed(prev_q);
	assign lo = $signed(TEMP_WIDTH'(cfg.margin_low));
	assign ce = $signed(TEMP_WIDTH'(cfg.margin_center));
	assign hi = $signed(TEMP_WIDTH'(cfg.margin_high));

	always_comb begin
		delta = DW'(t) - DW'(ce);
		adist = delta[DW-1] ? DW'(-delta) : DW'(delta);
		priority if (adist > DW'(2 * FRAC_ONE)) step = STEP_BIG;
		else if (adist > DW'(FRAC_ONE))         step = STEP_MID;
		else                                    step = STEP_SMALL;
	end

	assign passed = timer_q > cfg.holdoff_ticks;
	assign below  = t < lo;
	assign above  = t > hi;

	assign move_up = have_q && passed && below && (t < pv) && (drive_q < cfg.code_max);
	assign move_dn = have_q && passed && !below && above && (t > pv)
	                 && (drive_q > cfg.code_min);

	assign up_sum   = {1'b0, drive_q} + (CODE_W + 1)'(step);
	assign up_val   = (up_sum > {1'b0, cfg.code_max}) ? cfg.code_max : up_sum[CODE_W-1:0];
	assign dn_floor = {1'b0, cfg.code_min} + (CODE_W + 1)'(step);
	assign dn_val   = ({1'b0, drive_q} < dn_floor) ? cfg.code_min
	                                               : drive_q - CODE_W'(step);

	always_comb begin
		priority if (!have_q) res_drive = cfg.code_start;
		else if (move_up)     res_drive = up_val;
		else if (move_dn)     res_drive = dn_val;
		else                  res_drive = drive_q;
	end

	assign res_changed = move_up || move_dn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			have_q  <= 1'b0;
			drive_q <= '0;
			timer_q <= '0;
		end else if (go) begin
			if (!op) begin
				if (timer_q != TIMER_MAX) begin
					timer_q <= timer_q + TIMER_W'(1);
				end
			end else begin
				have_q  <= 1'b1;
				drive_q <= res_drive;
				prev_q  <= temp;
				if (!have_q || res_changed) begin
					timer_q <= '0;
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_move_restarts_timer: assert property (@(posedge clk) disable iff (!arst_n)
		(go && op && res_changed) |=> (timer_q == '0))
		else $error("code move did not restart hold-off timer");

	a_tick_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(go && !op && timer_q != TIMER_MAX) |=> (timer_q == $past(timer_q) + TIMER_W'(1)))
		else $error("tick did not advance hold-off timer");

	a_change_moves_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_changed |-> (have_q && res_drive != drive_q))
		else $error("change flagged without a code move");

	a_sample_arms: assert property (@(posedge clk) disable iff (!arst_n)
		(go && op) |=> have_q)
		else $error("sample did not mark first sample seen");
`endif

endmodule

### dv/tb_stepwise_temperature_regulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stepwise_temperature_regulator: testbench
// Streams ticks and temperature samples into the regulator and predicts
// every drive report. Each report is checked field by field. The run covers
// directed steps, an all-ones hold-off and a series of register settings.
// ----------------------------------------------------------------------------
module tb_stepwise_temperature_regulator;
	import srt_pkg::*;

	typedef struct {
		logic [CODE_W-1:0] drive;
		logic              changed;
	} drive_report_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [15:0]           s_tdata   = '0;   // sample_temp
	logic                  s_tuser   = 1'b0; // op
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [CODE_W-1:0]     m_tdata;          // drive_out
	logic                  m_tuser;          // code_changed

	// mirror of the regulator
	cfg_t               regs;
	logic [15:0]        last_temp;
	bit                 seen_sample;
	logic [CODE_W-1:0]  drive_code;
	logic [TIMER_W-1:0] hold_timer;
	drive_report_t      pending_reports[$];

	bit steady = 1'b0;
	int errors = 0;
	int items_sent = 0;
	int reports_seen = 0;
	int moves_seen = 0;
	int band_c, band_lo, band_hi;

	stepwise_temperature_regulator #(.TEMP_WIDTH(16)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void regulate(input bit op, input logic [15:0] raw);
		int t, trend, gap, stride;
		bit passed;
		drive_report_t r;
		r.changed = 1'b0;
		if (!op) begin
			if (hold_timer != TIMER_MAX)
				hold_timer++;
			return;
		end
		t = $signed(raw);
		if (!seen_sample) begin
			seen_sample = 1'b1;
			drive_code  = regs.code_start;
			hold_timer  = '0;
		end else begin
			trend  = t - $signed(last_temp);
			passed = hold_timer > regs.holdoff_ticks;
			gap    = t - $signed(regs.margin_center);
			if (gap < 0)
				gap = -gap;
			// exactly 1 or 2 degrees away takes the smaller step
			stride = (gap > 2 * FRAC_ONE) ? int'(STEP_BIG) :
			         (gap > FRAC_ONE) ? int'(STEP_MID) : int'(STEP_SMALL);
			if (t < $signed(regs.margin_low) && passed) begin
				if (trend < 0 && drive_code < regs.code_max) begin
					if (int'(drive_code) + stride > int'(regs.code_max))
						drive_code = regs.code_max;
					else
						drive_code = drive_code + CODE_W'(stride);
					r.changed  = 1'b1;
					hold_timer = '0;
				end
			end else if (t > $signed(regs.margin_high) && passed) begin
				if (trend > 0 && drive_code > regs.code_min) begin
					if (int'(drive_code) < int'(regs.code_min) + stride)
						drive_code = regs.code_min;
					else
						drive_code = drive_code - CODE_W'(stride);
					r.changed  = 1'b1;
					hold_timer = '0;
				end
			end
		end
		last_temp = raw;
		r.drive   = drive_code;
		if (r.changed)
			moves_seen++;
		pending_reports.push_back(r);
	endfunction

	always @(posedge clk) begin : check_reports
		drive_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			reports_seen++;
			if (pending_reports.size() == 0) begin
				errors++;
				$error("drive report with none pending: drive_out %0d, code_changed %0d",
					m_tdata, m_tuser);
			end else begin
				want = pending_reports.pop_front();
				if (m_tdata !== want.drive) begin
					errors++;
					$error("drive_out: expected %0d, actual %0d", want.drive, m_tdata);
				end
				if (m_tuser !== want.changed) begin
					errors++;
					$error("code_changed: expected %0d, actual %0d", want.changed, m_tuser);
				end
			end
		end
	end

	// receiver back-pressure
	always @(negedge clk)
		m_tready <= steady || ($urandom_range(99) >= 34);

	task automatic send_item(input bit op, input logic [15:0] temp);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 34) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= temp;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
		regulate(op, temp);
	endtask

	task automatic tick();
		send_item(1'b0, 16'($urandom_range(0, 65535)));
	endtask

	task automatic sample(input logic [15:0] temp);
		send_item(1'b1, temp);
	endtask

	// stop sending and wait for every report, plus pipeline slack for ticks
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_MARGIN_LOW:    regs.margin_low    = val;
			REG_MARGIN_CENTER: regs.margin_center = val;
			REG_MARGIN_HIGH:   regs.margin_high   = val;
			REG_CODE_MIN:      regs.code_min      = val[7:0];
			REG_CODE_START:    regs.code_start    = val[7:0];
			REG_CODE_MAX:      regs.code_max      = val[7:0];
			REG_HOLDOFF:       regs.holdoff_ticks = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_setting(input int lo, input int c, input int hi, input int cmin,
		input int cstart, input int cmax, input int hold);
		band_lo = lo;
		band_c  = c;
		band_hi = hi;
		write_reg(REG_MARGIN_LOW, lo[15:0]);
		write_reg(REG_MARGIN_CENTER, c[15:0]);
		write_reg(REG_MARGIN_HIGH, hi[15:0]);
		write_reg(REG_CODE_MIN, {8'h00, cmin[7:0]});
		write_reg(REG_CODE_START, {8'h00, cstart[7:0]});
		write_reg(REG_CODE_MAX, {8'h00, cmax[7:0]});
		write_reg(REG_HOLDOFF, hold[15:0]);
	endtask

	function automatic logic [15:0] pick_temp();
		int v, off, r;
		r   = $urandom_range(99);
		off = $urandom_range(0, 2400);
		if (r < 8) begin
			v = int'($urandom_range(0, 65535)) - 32768;
		end else if (r < 15) begin
			case ($urandom_range(6))
				0: v = -32768;
				1: v = 32767;
				2: v = band_lo;
				3: v = band_hi;
				4: v = band_c + 256;
				5: v = band_c - 512;
				default: v = band_c;
			endcase
		end else begin
			v = band_c + off - 1200;
		end
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	task automatic random_burst(input int count);
		repeat (count) begin
			if ($urandom_range(99) < 40)
				tick();
			else
				sample(pick_temp());
		end
	endtask

	task automatic test_directed_moves();
		apply_setting(24 * 256, 25 * 256, 26 * 256, 0, 252, 255, 0);
		sample(16'h1900);           // first sample loads start code
		tick();
		sample(16'h1400);           // far below, falling: big step clamps at max
		tick();
		sample(16'h1300);           // already at max
		sample(16'h1300);           // flat trend
		tick();
		sample(16'h1780);           // below but rising
		sample(16'h1800);           // low edge is inside
		sample(16'h1a00);           // high edge is inside
		sample(16'h1b00);           // above, rising, exactly 2 degrees out
		tick();
		sample(16'h1a80);           // above but falling
		sample(16'h1a01);
		tick();
		sample(16'h1a40);           // above, rising, 1.25 degrees out
		tick();
		sample(16'h7fff);
		tick();
		sample(16'h8000);
		sample(16'h7000);           // hold-off not yet passed
		sample(16'h8000);
	endtask

	task automatic test_holdoff_max();
		settle();
		write_reg(REG_HOLDOFF, TIMER_MAX);
		steady = 1'b1;
		repeat (20)
			tick();
		// no timer value exceeds an all-ones hold-off
		sample(16'h8002);
		sample(16'h8001);
		settle();
		write_reg(REG_HOLDOFF, TIMER_MAX - 16'd1);
		sample(16'h8000);
		steady = 1'b0;
	endtask

	task automatic test_random_settings();
		int k, c, lo, hi, cmin, cmax, hold;
		for (k = 0; k < 9; k++) begin
			settle();
			c    = int'($urandom_range(0, 60000)) - 30000;
			lo   = c - int'($urandom_range(0, 512));
			hi   = c + int'($urandom_range(0, 512));
			cmin = $urandom_range(0, 60);
			cmax = $urandom_range(190, 255);
			hold = $urandom_range(0, 5);
			steady = (k == 1);
			case (k)
				1: begin
					cmin = 0;
					cmax = 255;
					hold = 0;
				end
				2: begin
					// inverted code limits
					cmin = $urandom_range(150, 255);
					cmax = $urandom_range(0, 100);
				end
				3: begin
					// inverted band, code limits pinned to one value
					lo   = 32767;
					hi   = -32768;
					cmin = $urandom_range(0, 255);
					cmax = cmin;
				end
				4: begin
					c  = 0;
					lo = -32768;
					hi = 32767;
				end
				5: hold = int'(TIMER_MAX);
				default: ;
			endcase
			apply_setting(lo, c, hi, cmin, $urandom_range(0, 255), cmax, hold);
			if (k == 6) begin
				random_burst(85);
				settle();
				random_burst(85);
			end else begin
				random_burst(170);
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		#60_000_000;
		$display("stepwise_temperature_regulator verification failed");
		$finish;
	end

	initial begin
		regs.margin_low    = MARGIN_LOW_RST;
		regs.margin_center = MARGIN_CENTER_RST;
		regs.margin_high   = MARGIN_HIGH_RST;
		regs.code_min      = CODE_MIN_RST;
		regs.code_start    = CODE_START_RST;
		regs.code_max      = CODE_MAX_RST;
		regs.holdoff_ticks = HOLDOFF_RST;
		last_temp   = '0;
		seen_sample = 1'b0;
		drive_code  = '0;
		hold_timer  = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_moves();
		test_holdoff_max();
		test_random_settings();
		settle();
		repeat (8) @(posedge clk);

		$display("Sent %0d beats of ticks and samples, checked %0d drive reports, %0d code moves.",
			items_sent, reports_seen, moves_seen);
		$display("Covered band edges, step sizes, code limits, maximum hold-off and 9 settings.");
		if (errors == 0)
			$display("stepwise_temperature_regulator verification clean");
		else
			$display("stepwise_temperature_regulator verification failed");
		$finish;
	end

endmodule
